// ===== hdl/dlps_pkg.sv =====
// dlps_pkg: shared sizes and types for the delay line pitch shifter
`default_nettype none
package dlps_pkg;

  // the depth of the sample store must be a power of two
  localparam int BUFFER_DEPTH  = 4096;
  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;

  localparam int RATIO_W   = 19;
  localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
  localparam int POS_W     = ADDR_W + FRACTION_BITS;
  localparam int PAIR_W    = 2 * SAMPLE_BITS;
  localparam int TDATA_W   = ((PAIR_W + 7) / 8) * 8;
  localparam int PROD_W    = SAMPLE_BITS + FRACTION_BITS + 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1) << FRACTION_BITS;
  localparam logic [POS_W-1:0]   POS_RESET   =
    {ADDR_W'(BUFFER_DEPTH / 2), {FRACTION_BITS{1'b0}}};

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } front_st_e;

  // two neighboring entries per channel and the interpolation fraction
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left0;
    logic signed [SAMPLE_BITS-1:0] left1;
    logic signed [SAMPLE_BITS-1:0] right0;
    logic signed [SAMPLE_BITS-1:0] right1;
    logic [FRACTION_BITS-1:0]      frac;
  } interp_t;

  typedef struct packed {
    logic    valid;
    interp_t data;
  } push_t;

endpackage
`default_nettype wire

// ===== hdl/dlps_ram.sv =====
// dlps_ram: generic ram, one write port and two registered read ports
`default_nettype none
module dlps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dlps_front.sv =====
// dlps_front: store clearing, sample write, position tracking and neighbor reads
`default_nettype none
module dlps_front
  import dlps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [RATIO_W-1:0]    cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PAIR_W-1:0]     in_pair_i,
  input  wire logic [FIFO_CNT_W-1:0] fifo_count_i,
  output push_t                      push_o
);

  front_st_e                 state_q, state_d;
  logic [ADDR_W-1:0]         clr_addr_q;
  logic [RATIO_W-1:0]        ratio_q;
  logic [ADDR_W-1:0]         wi_q;
  logic [POS_W-1:0]          pos_q;
  logic [POS_W-1:0]          pos_sum;
  logic                      accept;
  logic [ADDR_W-1:0]         rd0, rd1;

  logic                      s1_valid_q;
  logic [FRACTION_BITS-1:0]  s1_frac_q;
  logic                      s1_byp0_q, s1_byp1_q;
  logic [PAIR_W-1:0]         s1_new_q;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [PAIR_W-1:0]         ram_wdata;
  logic [PAIR_W-1:0]         ram_rd0, ram_rd1;
  logic [PAIR_W-1:0]         ent0, ent1;

  // room for this word counting the one still waiting on the ram
  assign in_ready_o = (state_q == ST_RUN) &&
    ((FIFO_CNT_W + 1)'(fifo_count_i) + (FIFO_CNT_W + 1)'(s1_valid_q) <
     (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign accept = in_valid_i && in_ready_o;

  assign rd0 = pos_q[POS_W-1:FRACTION_BITS];
  assign rd1 = rd0 + ADDR_W'(1);

  // wraps modulo the store depth times the fraction scale
  assign pos_sum = pos_q + POS_W'(ratio_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == ADDR_W'(BUFFER_DEPTH - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wi_q;
    ram_wdata = in_pair_i;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (accept) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      ratio_q    <= RATIO_RESET;
      wi_q       <= '0;
      pos_q      <= POS_RESET;
      s1_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
      if (accept) begin
        wi_q  <= wi_q + ADDR_W'(1);
        pos_q <= pos_sum;
      end
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_frac_q <= pos_q[FRACTION_BITS-1:0];
      s1_byp0_q <= (rd0 == wi_q);
      s1_byp1_q <= (rd1 == wi_q);
      s1_new_q  <= in_pair_i;
    end
  end

  dlps_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (accept),
    .raddr0_i (rd0),
    .raddr1_i (rd1),
    .rdata0_o (ram_rd0),
    .rdata1_o (ram_rd1)
  );

  // a read at the write index must see the sample written with it
  assign ent0 = s1_byp0_q ? s1_new_q : ram_rd0;
  assign ent1 = s1_byp1_q ? s1_new_q : ram_rd1;

  assign push_o.valid       = s1_valid_q;
  assign push_o.data.left0  = ent0[SAMPLE_BITS-1:0];
  assign push_o.data.right0 = ent0[PAIR_W-1:SAMPLE_BITS];
  assign push_o.data.left1  = ent1[SAMPLE_BITS-1:0];
  assign push_o.data.right1 = ent1[PAIR_W-1:SAMPLE_BITS];
  assign push_o.data.frac   = s1_frac_q;

endmodule
`default_nettype wire

// ===== hdl/dlps_fifo.sv =====
// dlps_fifo: short queue of interpolation jobs between front and back
`default_nettype none
module dlps_fifo
  import dlps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire push_t                 push_i,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output interp_t                    data_o,
  output logic [FIFO_CNT_W-1:0]      count_o
);

  interp_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_q, rd_q;
  logic [FIFO_CNT_W-1:0]   cnt_q;
  logic                    do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i && valid_o;

  // the front only pushes when it holds a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i.valid) - FIFO_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dlps_back.sv =====
// dlps_back: linear interpolation of both channels and the output register
`default_nettype none
module dlps_back
  import dlps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  wire interp_t           job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [PAIR_W-1:0]      out_pair_o
);

  localparam int QW    = PROD_W - FRACTION_BITS;
  localparam int SUM_W = QW + 1;

  logic                          o_load, m_load;
  logic                          m_valid_q;
  logic signed [PROD_W-1:0]      m_prod_l_q, m_prod_r_q;
  logic signed [SAMPLE_BITS-1:0] m_s0_l_q, m_s0_r_q;
  logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
  logic signed [FRACTION_BITS:0] frac_s;
  logic                          o_valid_q;
  logic [SAMPLE_BITS-1:0]        o_left_q, o_right_q;
  logic [SAMPLE_BITS-1:0]        res_l, res_r;

  function automatic logic [SAMPLE_BITS-1:0] finish(
    input logic signed [PROD_W-1:0]      prod,
    input logic signed [SAMPLE_BITS-1:0] s0
  );
    logic signed [PROD_W-1:0]    rnd;
    logic signed [QW-1:0]        q;
    logic signed [SUM_W-1:0]     sum;
    logic [SUM_W-SAMPLE_BITS:0]  top;
    logic [SAMPLE_BITS-1:0]      res;
    // round half up, then floor by arithmetic shift
    rnd = prod + PROD_W'(1 << (FRACTION_BITS - 1));
    q   = rnd[PROD_W-1:FRACTION_BITS];
    sum = SUM_W'(q) + SUM_W'(s0);
    top = sum[SUM_W-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      res = sum[SAMPLE_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      res = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
    return res;
  endfunction

  assign o_load = !o_valid_q || out_ready_i;
  assign m_load = !m_valid_q || o_load;
  assign pop_o  = job_valid_i && m_load;

  assign diff_l = (SAMPLE_BITS + 1)'(job_i.left1) - (SAMPLE_BITS + 1)'(job_i.left0);
  assign diff_r = (SAMPLE_BITS + 1)'(job_i.right1) - (SAMPLE_BITS + 1)'(job_i.right0);
  assign frac_s = {1'b0, job_i.frac};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (m_load) begin
        m_valid_q <= pop_o;
      end
      if (o_load) begin
        o_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_prod_l_q <= PROD_W'(diff_l) * PROD_W'(frac_s);
      m_prod_r_q <= PROD_W'(diff_r) * PROD_W'(frac_s);
      m_s0_l_q   <= job_i.left0;
      m_s0_r_q   <= job_i.right0;
    end
    if (o_load && m_valid_q) begin
      o_left_q  <= res_l;
      o_right_q <= res_r;
    end
  end

  assign res_l = finish(m_prod_l_q, m_s0_l_q);
  assign res_r = finish(m_prod_r_q, m_s0_r_q);

  assign out_valid_o = o_valid_q;
  assign out_pair_o  = {o_right_q, o_left_q};

endmodule
`default_nettype wire

// ===== hdl/delay_line_pitch_shifter.sv =====
// delay_line_pitch_shifter: top level of the stereo delay line pitch shifter
//
//   channel   direction  handshake                     contents
//   s_axis    in         s_axis_tvalid/s_axis_tready   left_in, right_in
//   m_axis    out        m_axis_tvalid/m_axis_tready   left_out, right_out
//   cfg       in         cfg_we_i                      pitch_ratio
//
// one word per cycle sustained while m_axis_tready stays high; a taken word passes the ram
// read, which shares the accepting edge, then the queue, the multiply register and the
// output register on its way to m_axis.
// after reset a clearing pass zeroes the 4096-entry store, during which s_axis_tready
// stays low; cfg writes are taken throughout.
// a four-entry queue splits the store side from the arithmetic side, so m_axis stalls
// back up into s_axis only once the queue, counting the word still in the ram read, is full.
`default_nettype none
module delay_line_pitch_shifter
  import dlps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RATIO_W-1:0] cfg_wdata_i,   // pitch_ratio
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // left_in, right_in
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata   // left_out, right_out
);

  push_t                   push;
  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic                    job_valid;
  interp_t                 job;
  logic                    pop;
  logic [PAIR_W-1:0]       out_pair;

  dlps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pair_i    (s_axis_tdata[PAIR_W-1:0]),
    .fifo_count_i (fifo_count),
    .push_o       (push)
  );

  dlps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job),
    .count_o (fifo_count)
  );

  dlps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pair_o  (out_pair)
  );

  assign m_axis_tdata = TDATA_W'(out_pair);

endmodule
`default_nettype wire
